@@ hw/rtl/ise_pkg.sv @@
// Shared types and constants for the Ising energy minimum search block.
// Holds the queue command format, opcode and state enums.
// No dependencies.
package ise_pkg;

	localparam int MAX_SPINS_DEF = 32;
	localparam int COEF_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CFG_W     = 6;
	localparam int KIND_W    = 2;
	localparam int IDX_IN_W  = 9;
	localparam int COEF_IN_W = 16;
	localparam int WORD_W    = 32;
	localparam int RES_W     = 32;
	localparam int CMD_COEF_W = 32;

	localparam logic [KIND_W-1:0] KIND_LOAD_FIELD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_PAIR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVAL       = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR      = 2'd3;

	localparam logic [CFG_W-1:0] SPIN_COUNT_RST = 6'd1;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FIELD,
		OP_PAIR,
		OP_EVAL,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIELD,
		ST_PAIR,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                   op;
		logic [IDX_IN_W-1:0]   idx;
		logic [CMD_COEF_W-1:0] coef;
		logic [WORD_W-1:0]     word;
	} cmd_t;

endpackage

@@ hw/rtl/ise_if.sv @@
// Channel interfaces for the Ising energy minimum search block.
// ise_in_if carries input items, ise_out_if carries results.
// Depends on ise_pkg.
interface ise_in_if import ise_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [KIND_W-1:0]           kind;
	logic [IDX_IN_W-1:0]         entry_index;
	logic signed [COEF_IN_W-1:0] coef_value;
	logic [WORD_W-1:0]           spin_word;

	modport src (output valid, kind, entry_index, coef_value, spin_word, input ready);
	modport snk (input valid, kind, entry_index, coef_value, spin_word, output ready);
endinterface

interface ise_out_if import ise_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] energy_value;
	logic signed [RES_W-1:0] min_energy;

	modport src (output valid, energy_value, min_energy, input ready);
	modport snk (input valid, energy_value, min_energy, output ready);
endinterface

@@ hw/rtl/ise_front.sv @@
// Front end: accepts input items and turns them into queue commands.
// Range-checks load indexes and fits coefficients to COEF_BITS.
// Depends on ise_pkg and ise_if.
module ise_front import ise_pkg::*; #(
	parameter int MAX_SPINS = MAX_SPINS_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	ise_in_if.snk items_in,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	localparam int PAIR_DEPTH = MAX_SPINS * (MAX_SPINS - 1) / 2;

	logic                        field_ok;
	logic                        pair_ok;
	logic signed [COEF_BITS-1:0] coef_fit;

	assign items_in.ready = !q_full;
	assign q_push         = items_in.valid && !q_full;

	assign field_ok = 32'(items_in.entry_index) < 32'(MAX_SPINS);
	assign pair_ok  = 32'(items_in.entry_index) < 32'(PAIR_DEPTH);
	assign coef_fit = COEF_BITS'(items_in.coef_value);

	always_comb begin
		q_cmd.idx  = items_in.entry_index;
		q_cmd.coef = CMD_COEF_W'(coef_fit);
		q_cmd.word = items_in.spin_word;
		case (items_in.kind)
			KIND_LOAD_FIELD: q_cmd.op = field_ok ? OP_FIELD : OP_NOP;
			KIND_LOAD_PAIR:  q_cmd.op = pair_ok ? OP_PAIR : OP_NOP;
			KIND_EVAL:       q_cmd.op = OP_EVAL;
			KIND_CLEAR:      q_cmd.op = OP_CLEAR;
			default:         q_cmd.op = OP_NOP;
		endcase
	end

endmodule

@@ hw/rtl/ise_queue.sv @@
// Short command queue between the front end and the evaluation engine.
// Register-based ring of QUEUE_DEPTH entries.
// Depends on ise_pkg.
module ise_queue import ise_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/ise_back.sv @@
// Evaluation engine: field and coupling memories, term sequencer,
// accumulator, saturation, running minimum and result register.
// Depends on ise_pkg and ise_if.
module ise_back import ise_pkg::*; #(
	parameter int MAX_SPINS = MAX_SPINS_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] spin_count,
	input  logic             q_valid,
	input  cmd_t             q_head,
	output logic             q_pop,
	ise_out_if.src           results_out
);

	localparam int PAIR_DEPTH = MAX_SPINS * (MAX_SPINS - 1) / 2;
	localparam int IDX_W = $clog2(MAX_SPINS);
	localparam int CNT_W = $clog2(MAX_SPINS + 1);
	localparam int PA_W  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
	localparam int ACC_W = COEF_BITS + $clog2(MAX_SPINS + PAIR_DEPTH) + 1;
	localparam int SAT_W = (ACC_W > RES_W) ? ACC_W : RES_W + 1;
	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};
	localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(RES_MAX);
	localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(RES_MIN);

	logic signed [COEF_BITS-1:0] field_mem [MAX_SPINS];
	logic signed [COEF_BITS-1:0] pair_mem [PAIR_DEPTH];

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        n_q;
	logic [WORD_W-1:0]       word_q;
	logic [IDX_W-1:0]        a_q;
	logic [IDX_W-1:0]        b_q;
	logic [PA_W-1:0]         k_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [RES_W-1:0] min_q;
	logic                    out_valid_q;
	logic signed [RES_W-1:0] energy_q;
	logic signed [RES_W-1:0] min_out_q;

	logic signed [COEF_BITS-1:0] field_rd_s1;
	logic signed [COEF_BITS-1:0] pair_rd_s1;
	logic                        term_vld_s1;
	logic                        negate_s1;
	logic                        pair_s1;

	logic [CNT_W-1:0] n_eff;
	logic             spin_a;
	logic             spin_b;
	logic             field_last;
	logic             b_last;
	logic             a_last;
	logic             out_free;

	// FSM outputs
	logic             pop_item;
	logic             start_eval;
	logic             issue_field;
	logic             issue_pair;
	logic             load_out;

	logic [WORD_W-1:0]       sh_a;
	logic [WORD_W-1:0]       sh_b;
	logic signed [ACC_W-1:0] term;
	logic signed [SAT_W-1:0] acc_x;
	logic signed [RES_W-1:0] energy_sat;
	logic signed [RES_W-1:0] min_next;

	assign n_eff = ({1'b0, spin_count} > (CFG_W + 1)'(MAX_SPINS)) ?
		CNT_W'(MAX_SPINS) : CNT_W'(spin_count);

	assign sh_a   = word_q >> a_q;
	assign sh_b   = word_q >> b_q;
	assign spin_a = sh_a[0];
	assign spin_b = sh_b[0];

	assign field_last = (CNT_W'(a_q) + CNT_W'(1)) == n_q;
	assign b_last     = (CNT_W'(b_q) + CNT_W'(1)) == n_q;
	assign a_last     = (CNT_W'(a_q) + CNT_W'(2)) == n_q;
	assign out_free   = !out_valid_q || results_out.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_head.op == OP_EVAL) begin
					state_d = (n_eff == '0) ? ST_DRAIN : ST_FIELD;
				end
			end
			ST_FIELD: begin
				if (field_last) begin
					state_d = (n_q >= CNT_W'(2)) ? ST_PAIR : ST_DRAIN;
				end
			end
			ST_PAIR: begin
				if (b_last && a_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop_item    = 1'b0;
		start_eval  = 1'b0;
		issue_field = 1'b0;
		issue_pair  = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_item   = q_valid;
				start_eval = q_valid && q_head.op == OP_EVAL;
			end
			ST_FIELD:  issue_field = 1'b1;
			ST_PAIR:   issue_pair = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: load_out = out_free;
			default:   ;
		endcase
	end

	assign q_pop = pop_item;

	// coefficient memories, registered read
	always_ff @(posedge clk) begin
		if (pop_item && q_head.op == OP_FIELD) begin
			field_mem[IDX_W'(q_head.idx)] <= COEF_BITS'(q_head.coef);
		end
		field_rd_s1 <= field_mem[a_q];
	end

	always_ff @(posedge clk) begin
		if (pop_item && q_head.op == OP_PAIR) begin
			pair_mem[PA_W'(q_head.idx)] <= COEF_BITS'(q_head.coef);
		end
		pair_rd_s1 <= pair_mem[k_q];
	end

	assign term = pair_s1 ? ACC_W'(pair_rd_s1) : ACC_W'(field_rd_s1);

	assign acc_x      = SAT_W'(acc_q);
	assign energy_sat = (acc_x > SAT_MAX) ? RES_MAX :
		(acc_x < SAT_MIN) ? RES_MIN : RES_W'(acc_x);
	assign min_next   = (energy_sat < min_q) ? energy_sat : min_q;

	always_ff @(posedge clk) begin
		if (start_eval) begin
			word_q <= q_head.word;
			n_q    <= n_eff;
		end
		if (load_out) begin
			energy_q  <= energy_sat;
			min_out_q <= min_next;
		end
		// field term is -h*s, pair term is -J*s_a*s_b; bit set means spin -1
		negate_s1 <= issue_field ? !spin_a : (spin_a == spin_b);
		pair_s1   <= issue_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			min_q       <= RES_MAX;
			out_valid_q <= 1'b0;
			term_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			term_vld_s1 <= issue_field || issue_pair;
			if (pop_item && q_head.op == OP_CLEAR) begin
				min_q <= RES_MAX;
			end
			if (start_eval) begin
				a_q   <= '0;
				acc_q <= '0;
			end else if (term_vld_s1) begin
				acc_q <= negate_s1 ? acc_q - term : acc_q + term;
			end
			if (issue_field) begin
				if (field_last) begin
					a_q <= '0;
					b_q <= IDX_W'(1);
					k_q <= '0;
				end else begin
					a_q <= a_q + IDX_W'(1);
				end
			end
			if (issue_pair) begin
				k_q <= k_q + PA_W'(1);
				if (b_last) begin
					a_q <= a_q + IDX_W'(1);
					b_q <= a_q + IDX_W'(1) + IDX_W'(1);
				end else begin
					b_q <= b_q + IDX_W'(1);
				end
			end
			if (load_out) begin
				min_q       <= min_next;
				out_valid_q <= 1'b1;
			end else if (results_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results_out.valid        = out_valid_q;
	assign results_out.energy_value = energy_q;
	assign results_out.min_energy   = min_out_q;

endmodule

@@ hw/rtl/ising_energy_min_search.sv @@
// Evaluate: from input acceptance with the engine idle, the field terms, then the coupling
// terms, then the drain and finish states lead to a valid result (one stored field or
// coupling read per cycle from its memory port). Load and clear items are handled in idle.
// Input side takes items into a two-entry queue while the engine is busy.
// Reset: spin_count = 1, minimum = largest positive value, queue and result empty;
// field and coupling memories are undefined until written.
module ising_energy_min_search import ise_pkg::*; #(
	parameter int MAX_SPINS = MAX_SPINS_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	ise_in_if.snk            items_in,
	ise_out_if.src           results_out
);

	logic [CFG_W-1:0] spin_count_q;
	logic             q_full;
	logic             q_push;
	cmd_t             q_cmd;
	logic             q_pop;
	logic             q_valid;
	cmd_t             q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_count_q <= SPIN_COUNT_RST;
		end else if (cfg_valid) begin
			spin_count_q <= cfg_data;
		end
	end

	ise_front #(
		.MAX_SPINS(MAX_SPINS),
		.COEF_BITS(COEF_BITS)
	) u_front (
		.items_in(items_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	ise_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head     (q_head)
	);

	ise_back #(
		.MAX_SPINS(MAX_SPINS),
		.COEF_BITS(COEF_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.spin_count (spin_count_q),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.results_out(results_out)
	);

endmodule

@@ hw/rtl/ise_checker.sv @@
// Port-level checks for ising_energy_min_search, attached by bind.
// Watches the result channel over time.
// Depends on ise_pkg.
module ise_checker import ise_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [RES_W-1:0] energy_value,
	input logic signed [RES_W-1:0] min_energy
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(energy_value) && $stable(min_energy))
		else $error("result changed while stalled");

	// running minimum includes the item's own energy
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_energy <= energy_value)
		else $error("min_energy above energy_value");

	// result register comes out of reset empty
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// a result never shows up straight out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n))
		else $error("result appeared right out of reset");

endmodule

bind ising_energy_min_search ise_checker u_ise_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results_out.valid),
	.out_ready   (results_out.ready),
	.energy_value(results_out.energy_value),
	.min_energy  (results_out.min_energy)
);
